// ===== rtl/ssev_pkg.sv =====
// Shared types and constants of the sprite scanline evaluator.
`timescale 1ns / 1ps

package ssev_pkg;

  // Attribute memory geometry: 256 bytes held as 64 four-byte words.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned WORDS   = 64;
  localparam int unsigned WORD_AW = 6;
  localparam int unsigned LINE_W  = 9;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned HEIGHT_W = 5;

  localparam logic [BYTE_W-1:0]   EMPTY_BYTE   = 8'hFF;
  localparam logic [HEIGHT_W-1:0] SHORT_HEIGHT = 5'd8;

  // Parameter defaults for the top level.
  localparam int unsigned ENTRIES_DEF       = 64;
  localparam int unsigned SLOTS_DEF         = 8;
  localparam int unsigned VISIBLE_LINES_DEF = 240;

  typedef enum logic [1:0] {
    OP_SET_ADDR = 2'd0,
    OP_WRITE    = 2'd1,
    OP_READ     = 2'd2,
    OP_EVAL     = 2'd3
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic [BYTE_W-1:0]  address_value;
    logic [BYTE_W-1:0]  write_byte;
    logic [LINE_W-1:0]  scanline;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic [BYTE_W-1:0]  sprite_y;
    logic [BYTE_W-1:0]  sprite_tile;
    logic [BYTE_W-1:0]  sprite_attr;
    logic [BYTE_W-1:0]  sprite_x;
    logic               slot_filled;
    logic [COUNT_W-1:0] sprite_count;
    logic               sprite_zero_found;
    logic               overflow;
    logic [MASK_W-1:0]  selected_mask;
    logic               last;
  } result_t;

  // One-port-write, one-port-read request to the attribute memory.
  typedef struct packed {
    logic                we;
    logic [3:0]          be;
    logic [WORD_AW-1:0]  waddr;
    logic [WORD_W-1:0]   wdata;
    logic [WORD_AW-1:0]  raddr;
  } ram_req_t;

endpackage

// ===== rtl/ssev_oam_ram.sv =====
// Attribute memory: 64 x 32-bit words, byte-enable write, registered read.
`timescale 1ns / 1ps

module ssev_oam_ram
  import ssev_pkg::*;
(
  input  logic              clk_i,
  input  ram_req_t          req_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [WORDS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      for (int b = 0; b < 4; b++) begin
        if (req_i.be[b]) begin
          mem_q[req_i.waddr][b*BYTE_W +: BYTE_W] <= req_i.wdata[b*BYTE_W +: BYTE_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ssev_slot_buf.sv =====
// Slot buffer: holds the words of the entries picked for the current line.
`timescale 1ns / 1ps

module ssev_slot_buf
  import ssev_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [SIW-1:0]    wr_idx_i,
  input  logic [WORD_W-1:0] wr_word_i,
  input  logic [SIW-1:0]    rd_idx_i,
  output logic [WORD_W-1:0] rd_word_o
);

  logic [WORD_W-1:0] slot_q [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_q[wr_idx_i] <= wr_word_i;
    end
  end

  assign rd_word_o = slot_q[rd_idx_i];

endmodule

// ===== rtl/sprite_scanline_evaluator.sv =====
// Top level: command decode, entry scan sequencer and result register.
`timescale 1ns / 1ps

// Set address and write byte finish when accepted and give no result.
// Read byte: the addressed word is read, then one result is registered.
// Evaluate: a scan with one memory read per entry, then SLOTS results on
// consecutive cycles; off-screen lines skip the scan.
// Reset: busy stays high during a clearing pass over every memory word.
// Results cannot be stalled; each one is strobed for exactly one cycle.

module sprite_scanline_evaluator
  import ssev_pkg::*;
#(
  parameter int unsigned ENTRIES       = ENTRIES_DEF,
  parameter int unsigned SLOTS         = SLOTS_DEF,
  parameter int unsigned VISIBLE_LINES = VISIBLE_LINES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd_i,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam int unsigned EIW = $clog2(ENTRIES);
  localparam int unsigned ECW = $clog2(ENTRIES + 1);
  localparam int unsigned SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW  = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [BYTE_W-1:0]  addr_q, addr_d;       // host byte pointer
  logic               tall_q;                // 16-line sprites
  logic [WORD_AW-1:0] clr_q, clr_d;          // clearing pass word index
  logic [LINE_W-1:0]  line_q, line_d;
  logic [ECW-1:0]     issue_q, issue_d;      // next entry to read
  logic               rvalid_q, rvalid_d;    // memory data holds an entry
  logic [EIW-1:0]     ridx_q, ridx_d;        // entry index of memory data
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               zero_q, zero_d;
  logic               over_q, over_d;
  logic [ENTRIES-1:0] mask_q, mask_d;
  logic [SIW-1:0]     emit_q, emit_d;
  result_t            res_q, res_d;
  logic               res_valid_q, res_valid_d;

  ram_req_t           ram_req;
  logic [WORD_W-1:0]  ram_rdata;
  logic               slot_we;
  logic [WORD_W-1:0]  slot_word;

  logic               accept;
  logic [LINE_W-1:0]  entry_y;
  logic [HEIGHT_W-1:0] height;
  logic               hit;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Y byte sits in the lowest lane of each entry word.
  assign entry_y = LINE_W'(ram_rdata[BYTE_W-1:0]);
  assign height  = tall_q ? (SHORT_HEIGHT << 1) : SHORT_HEIGHT;
  assign hit     = (entry_y <= line_q) && ((line_q - entry_y) < LINE_W'(height));

  ssev_oam_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  ssev_slot_buf #(
    .SLOTS (SLOTS),
    .SIW   (SIW)
  ) u_slots (
    .clk_i     (clk_i),
    .wr_en_i   (slot_we),
    .wr_idx_i  (cnt_q[SIW-1:0]),
    .wr_word_i (ram_rdata),
    .rd_idx_i  (emit_q),
    .rd_word_o (slot_word)
  );

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    clr_d       = clr_q;
    line_d      = line_q;
    issue_d     = issue_q;
    rvalid_d    = 1'b0;
    ridx_d      = ridx_q;
    cnt_d       = cnt_q;
    zero_d      = zero_q;
    over_d      = over_q;
    mask_d      = mask_q;
    emit_d      = emit_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    slot_we     = 1'b0;

    // Host reads use the word under the pointer; the scan walks entries.
    ram_req       = '0;
    ram_req.raddr = addr_q[BYTE_W-1:2];

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep zeros through every word, one per cycle.
        ram_req.we    = 1'b1;
        ram_req.be    = 4'hF;
        ram_req.waddr = clr_q;
        clr_d         = clr_q + 1'b1;
        if (clr_q == WORD_AW'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i.operation)
            OP_SET_ADDR: begin
              addr_d = cmd_i.address_value;
            end
            OP_WRITE: begin
              // Store one byte lane, advance the pointer with 8-bit wrap.
              ram_req.we    = 1'b1;
              ram_req.be    = 4'b0001 << addr_q[1:0];
              ram_req.waddr = addr_q[BYTE_W-1:2];
              ram_req.wdata = {4{cmd_i.write_byte}};
              addr_d        = addr_q + 1'b1;
            end
            OP_READ: begin
              state_d = ST_READ;
            end
            OP_EVAL: begin
              line_d  = cmd_i.scanline;
              issue_d = '0;
              cnt_d   = '0;
              zero_d  = 1'b0;
              over_d  = 1'b0;
              mask_d  = '0;
              emit_d  = '0;
              // Off-screen lines select nothing: go straight to the slots.
              state_d = (cmd_i.scanline < LINE_W'(VISIBLE_LINES)) ? ST_SCAN : ST_EMIT;
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        res_d                   = '0;
        res_d.read_byte         = ram_rdata[addr_q[1:0]*BYTE_W +: BYTE_W];
        res_d.sprite_y          = EMPTY_BYTE;
        res_d.sprite_tile       = EMPTY_BYTE;
        res_d.sprite_attr       = EMPTY_BYTE;
        res_d.sprite_x          = EMPTY_BYTE;
        res_d.last              = 1'b1;
        res_valid_d             = 1'b1;
        state_d                 = ST_IDLE;
      end

      ST_SCAN: begin
        // Issue one entry read per cycle; data returns in the following cycle.
        ram_req.raddr = WORD_AW'(issue_q[EIW-1:0]);
        if (issue_q != ECW'(ENTRIES)) begin
          rvalid_d = 1'b1;
          ridx_d   = issue_q[EIW-1:0];
          issue_d  = issue_q + 1'b1;
        end
        if (rvalid_q) begin
          if (hit && (cnt_q == CW'(SLOTS))) begin
            // A match past the last slot ends the walk; drop in-flight reads.
            over_d   = 1'b1;
            rvalid_d = 1'b0;
            state_d  = ST_EMIT;
          end else begin
            if (hit) begin
              slot_we        = 1'b1;
              cnt_d          = cnt_q + 1'b1;
              mask_d[ridx_q] = 1'b1;
              if (ridx_q == '0) begin
                zero_d = 1'b1;
              end
            end
            if (ridx_q == EIW'(ENTRIES - 1)) begin
              rvalid_d = 1'b0;
              state_d  = ST_EMIT;
            end
          end
        end
      end

      ST_EMIT: begin
        res_d.read_byte         = '0;
        res_d.slot_filled       = (CW'(emit_q) < cnt_q);
        res_d.sprite_y          = EMPTY_BYTE;
        res_d.sprite_tile       = EMPTY_BYTE;
        res_d.sprite_attr       = EMPTY_BYTE;
        res_d.sprite_x          = EMPTY_BYTE;
        if (CW'(emit_q) < cnt_q) begin
          res_d.sprite_y    = slot_word[0*BYTE_W +: BYTE_W];
          res_d.sprite_tile = slot_word[1*BYTE_W +: BYTE_W];
          res_d.sprite_attr = slot_word[2*BYTE_W +: BYTE_W];
          res_d.sprite_x    = slot_word[3*BYTE_W +: BYTE_W];
        end
        res_d.sprite_count      = COUNT_W'(cnt_q);
        res_d.sprite_zero_found = zero_q;
        res_d.overflow          = over_q;
        res_d.selected_mask     = MASK_W'(mask_q);
        res_d.last              = (emit_q == SIW'(SLOTS - 1));
        res_valid_d             = 1'b1;
        emit_d                  = emit_q + 1'b1;
        if (emit_q == SIW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      tall_q      <= 1'b0;
      clr_q       <= '0;
      issue_q     <= '0;
      rvalid_q    <= 1'b0;
      cnt_q       <= '0;
      zero_q      <= 1'b0;
      over_q      <= 1'b0;
      mask_q      <= '0;
      emit_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      clr_q       <= clr_d;
      issue_q     <= issue_d;
      rvalid_q    <= rvalid_d;
      cnt_q       <= cnt_d;
      zero_q      <= zero_d;
      over_q      <= over_d;
      mask_q      <= mask_d;
      emit_q      <= emit_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        tall_q <= cfg_wdata_i;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    line_q <= line_d;
    ridx_q <= ridx_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A strobe only ever follows a read or a slot emission cycle.
  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == ST_READ || $past(state_q) == ST_EMIT))
    else $error("result strobe without a source state");

  // The pick count never runs past the slot table.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS))
    else $error("slot count exceeds slot table");

  // Overflow is only flagged once every slot is taken.
  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q |-> (cnt_q == CW'(SLOTS)))
    else $error("overflow with free slots");

  // An off-screen evaluation skips the scan entirely.
  a_offscreen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.operation == OP_EVAL && cmd_i.scanline >= LINE_W'(VISIBLE_LINES))
    |=> (state_q == ST_EMIT && cnt_q == '0))
    else $error("off-screen line entered scan");

endmodule
